/* rtl/binomial_last_nonzero_digit_top_assert.svh */
// Assertion macros shared by the binomial last-digit RTL.
// Expects a clock named aclk and an active-low reset named aresetn in the including module.
`ifndef BINOMIAL_LAST_NONZERO_DIGIT_TOP_ASSERT_SVH
`define BINOMIAL_LAST_NONZERO_DIGIT_TOP_ASSERT_SVH

// Same-cycle implication.
`define BLD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BLD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bld_pkg.sv */
// Types, constants and digit tables for the binomial last non-zero digit block.
// No dependencies.
package bld_pkg;

    localparam int ARG_WIDTH = 32;
    localparam int IN_W      = 32;
    // Arguments are the low ARG_WIDTH bits of the 32-bit input fields.
    localparam int VAL_W     = (ARG_WIDTH < IN_W) ? ARG_WIDTH : IN_W;
    localparam int CNT_W     = VAL_W;
    localparam int DIGIT_W   = 4;

    // Divide by 5 as q = (w * RECIP5) >> SHIFT5, exact for every VAL_W-bit w.
    localparam int SHIFT5    = VAL_W + 5;
    localparam int RCP_W     = VAL_W + 3;
    localparam int PROD_W    = VAL_W + RCP_W;
    localparam logic [63:0] RECIP5_WIDE = ((64'd1 << SHIFT5) + 64'd4) / 64'd5;
    localparam logic [RCP_W-1:0] RECIP5 = RECIP5_WIDE[RCP_W-1:0];

    localparam logic [DIGIT_W-1:0] DIGIT_NONE  = 4'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
    localparam logic [DIGIT_W-1:0] END_THREE   = 4'd3;
    localparam logic [DIGIT_W-1:0] END_SEVEN   = 4'd7;
    localparam logic [DIGIT_W-1:0] END_NINE    = 4'd9;

    // Odd part: 3^k mod 10 (7 = 3^3, 9 = 3^2 mod 10).
    localparam logic [DIGIT_W-1:0] CYC_THREE [4] = '{4'd1, 4'd3, 4'd9, 4'd7};
    // (cycle 6,2,4,8 at e) times 3^k, mod 10.
    localparam logic [DIGIT_W-1:0] DIGIT_EVEN [4][4] = '{
        '{4'd6, 4'd8, 4'd4, 4'd2},
        '{4'd2, 4'd6, 4'd8, 4'd4},
        '{4'd4, 4'd2, 4'd6, 4'd8},
        '{4'd8, 4'd4, 4'd2, 4'd6}
    };

    typedef struct packed {
        logic [IN_W-1:0] n_total;
        logic [IN_W-1:0] k_chosen;
    } bld_in_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               invalid;
    } bld_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] pow2;
        logic [CNT_W-1:0] pow5;
        logic [1:0]       res3;
        logic [1:0]       res7;
        logic [1:0]       res9;
        logic             invalid;
    } bld_tally_t;

    typedef struct packed {
        logic idle;
        logic done;
    } bld_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARG,
        ST_OUTER,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } bld_state_t;

    typedef enum logic [1:0] {
        ARG_N,
        ARG_DIFF,
        ARG_K
    } bld_arg_t;

endpackage

/* rtl/binomial_last_nonzero_digit_top.sv */
// Top level of the binomial last non-zero digit block: handshakes, digit assembly, result register.
// Depends on bld_pkg, bld_core and the assertion macro header.
//
// Returns the last non-zero decimal digit of C(n, k) for one item {n_total, k_chosen} at a
// time. Both arguments are taken as their low ARG_WIDTH bits. When k > n the result has
// invalid = 1 and digit = 0 and the sequencer goes straight to ST_DONE. Otherwise a
// single shared divide-by-5 unit (a reciprocal multiply with a registered quotient) walks
// each of n, n - k and k: ST_ARG loads the argument, then for every halving v of it ST_OUTER
// runs once, followed by ST_DIV and ST_ACC per division of v by 5 until the quotient
// reaches zero, and a closing ST_OUTER once v is zero moves to the next argument. After the
// last argument ST_DONE hands the result to the output register. The walk lengthens with
// the size of the arguments. s_ready is high only while the sequencer is idle. The
// finished result moves into an output register, so the next item can be taken while it
// waits on m_ready; the sequencer holds a second finished result until that register is free.
// No clearing pass follows reset.
`include "binomial_last_nonzero_digit_top_assert.svh"

module binomial_last_nonzero_digit_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bld_pkg::bld_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bld_pkg::bld_out_t m_data
);

    bld_pkg::bld_ctl_t   ctl;
    bld_pkg::bld_tally_t tally;

    logic              m_valid_reg, m_valid_next;
    bld_pkg::bld_out_t m_data_reg, m_data_next;
    logic              out_free;
    logic [1:0]        two_idx, odd_idx;

    // Output slot frees up when it is empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = ctl.idle;

    bld_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_valid && s_ready),
        .start_args (s_data),
        .out_free   (out_free),
        .ctl        (ctl),
        .tally      (tally)
    );

    // Excess power of 2 picks from 6,2,4,8; the end-digit counts fold into one power of 3,
    // since 7 and 9 are 3^3 and 3^2 mod 10
    assign two_idx = tally.pow2[1:0] - tally.pow5[1:0];
    assign odd_idx = tally.res3 - tally.res7 + {tally.res9[0], 1'b0};

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctl.done) begin
            m_valid_next        = 1'b1;
            m_data_next.invalid = tally.invalid;
            if (tally.invalid) begin
                m_data_next.digit = bld_pkg::DIGIT_NONE;
            end else if (tally.pow2 < tally.pow5) begin
                m_data_next.digit = bld_pkg::DIGIT_FIVE;
            end else if (tally.pow2 == tally.pow5) begin
                m_data_next.digit = bld_pkg::CYC_THREE[odd_idx];
            end else begin
                m_data_next.digit = bld_pkg::DIGIT_EVEN[two_idx][odd_idx];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BLD_ASSERT_IMP(a_digit_vs_invalid, m_valid_reg,
        (m_data_reg.digit == bld_pkg::DIGIT_NONE) == m_data_reg.invalid,
        "zero digit must mark an invalid item")
    `BLD_ASSERT_IMP(a_done_has_room, ctl.done, !m_valid_reg || m_ready,
        "result finished while output register is full")
    `BLD_ASSERT_NXT(a_hold_result, m_valid_reg && !m_ready,
        m_valid_reg && $stable(m_data_reg), "waiting result dropped or changed")

endmodule

/* rtl/bld_div5.sv */
// Shared divide-by-5 unit: reciprocal multiply with a registered quotient.
// Depends on bld_pkg.
module bld_div5 (
    input  logic                      aclk,
    input  logic [bld_pkg::VAL_W-1:0] w,
    output logic [bld_pkg::VAL_W-1:0] q_reg
);

    logic [bld_pkg::PROD_W-1:0] prod;
    logic [bld_pkg::VAL_W-1:0]  q_next;

    assign prod   = bld_pkg::PROD_W'(w) * bld_pkg::PROD_W'(bld_pkg::RECIP5);
    assign q_next = bld_pkg::VAL_W'(prod[bld_pkg::PROD_W-1:bld_pkg::SHIFT5]);

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

endmodule

/* rtl/bld_core.sv */
// Sequencer and tallies: Legendre counts of 2 and 5 and end-digit counts mod 4.
// Depends on bld_pkg, bld_div5 and the assertion macro header.
`include "binomial_last_nonzero_digit_top_assert.svh"

module bld_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  bld_pkg::bld_in_t    start_args,
    input  logic                out_free,
    output bld_pkg::bld_ctl_t   ctl,
    output bld_pkg::bld_tally_t tally
);

    bld_pkg::bld_state_t state_reg, state_next;
    bld_pkg::bld_arg_t   arg_reg, arg_next;
    logic                first_reg, first_next;
    logic                inv_reg, inv_next;

    logic [bld_pkg::VAL_W-1:0] n_reg, n_next;
    logic [bld_pkg::VAL_W-1:0] m_reg, m_next;
    logic [bld_pkg::VAL_W-1:0] v_reg, v_next;
    logic [bld_pkg::VAL_W-1:0] w_reg, w_next;
    logic [bld_pkg::CNT_W-1:0] pow2_reg, pow2_next;
    logic [bld_pkg::CNT_W-1:0] pow5_reg, pow5_next;
    logic [1:0]                res3_reg, res3_next;
    logic [1:0]                res7_reg, res7_next;
    logic [1:0]                res9_reg, res9_next;

    logic [bld_pkg::VAL_W-1:0] n_in, m_in, arg_val, q;
    logic                      start_inv, v_zero, q_zero, neg;
    logic                      do_load, do_arg, do_outer, do_next_arg, do_acc;
    logic [2:0]                r5;
    logic [3:0]                r10;
    logic [1:0]                half_lo, inc3, inc7, inc9;

    bld_div5 u_div5 (
        .aclk  (aclk),
        .w     (w_reg),
        .q_reg (q)
    );

    assign n_in      = start_args.n_total[bld_pkg::VAL_W-1:0];
    assign m_in      = start_args.k_chosen[bld_pkg::VAL_W-1:0];
    assign start_inv = m_in > n_in;
    assign v_zero    = v_reg == '0;
    assign q_zero    = q == '0;
    assign neg       = arg_reg != bld_pkg::ARG_N;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bld_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = start_inv ? bld_pkg::ST_DONE : bld_pkg::ST_ARG;
                end
            end
            bld_pkg::ST_ARG: begin
                state_next = bld_pkg::ST_OUTER;
            end
            bld_pkg::ST_OUTER: begin
                if (!v_zero) begin
                    state_next = bld_pkg::ST_DIV;
                end else if (arg_reg == bld_pkg::ARG_K) begin
                    state_next = bld_pkg::ST_DONE;
                end else begin
                    state_next = bld_pkg::ST_ARG;
                end
            end
            bld_pkg::ST_DIV: begin
                state_next = bld_pkg::ST_ACC;
            end
            bld_pkg::ST_ACC: begin
                state_next = q_zero ? bld_pkg::ST_OUTER : bld_pkg::ST_DIV;
            end
            bld_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bld_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bld_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath strobes
    always_comb begin
        ctl.idle    = state_reg == bld_pkg::ST_IDLE;
        ctl.done    = (state_reg == bld_pkg::ST_DONE) && out_free;
        do_load     = (state_reg == bld_pkg::ST_IDLE) && start;
        do_arg      = state_reg == bld_pkg::ST_ARG;
        do_outer    = (state_reg == bld_pkg::ST_OUTER) && !v_zero;
        do_next_arg = (state_reg == bld_pkg::ST_OUTER) && v_zero
                      && (arg_reg != bld_pkg::ARG_K);
        do_acc      = state_reg == bld_pkg::ST_ACC;
    end

    // Current argument: n, then n - m, then m
    always_comb begin
        unique case (arg_reg)
            bld_pkg::ARG_N:    arg_val = n_reg;
            bld_pkg::ARG_DIFF: arg_val = n_reg - m_reg;
            bld_pkg::ARG_K:    arg_val = m_reg;
            default:           arg_val = m_reg;
        endcase
    end

    // One inner step: w = 5q + r5, w/10 = q >> 1, w%10 = r5 + 5*q[0]
    always_comb begin
        r5      = w_reg[2:0] - ({q[0], 2'b00} + q[2:0]);
        r10     = {1'b0, r5} + (q[0] ? 4'd5 : 4'd0);
        half_lo = q[2:1];
        inc3    = half_lo + 2'(r10 >= bld_pkg::END_THREE);
        inc7    = half_lo + 2'(r10 >= bld_pkg::END_SEVEN);
        inc9    = half_lo + 2'(r10 >= bld_pkg::END_NINE);
    end

    always_comb begin
        arg_next   = arg_reg;
        first_next = first_reg;
        inv_next   = inv_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        pow2_next  = pow2_reg;
        pow5_next  = pow5_reg;
        res3_next  = res3_reg;
        res7_next  = res7_reg;
        res9_next  = res9_reg;
        if (do_load) begin
            n_next    = n_in;
            m_next    = m_in;
            inv_next  = start_inv;
            arg_next  = bld_pkg::ARG_N;
            pow2_next = '0;
            pow5_next = '0;
            res3_next = '0;
            res7_next = '0;
            res9_next = '0;
        end
        if (do_arg) begin
            v_next     = arg_val;
            first_next = 1'b1;
        end
        if (do_outer) begin
            // Power of 2: add v >> 1 for every halving of the argument (subtract for n - m and m)
            pow2_next = neg ? pow2_reg - bld_pkg::CNT_W'(v_reg >> 1)
                            : pow2_reg + bld_pkg::CNT_W'(v_reg >> 1);
            w_next    = v_reg;
        end
        if (do_next_arg) begin
            unique case (arg_reg)
                bld_pkg::ARG_N:    arg_next = bld_pkg::ARG_DIFF;
                bld_pkg::ARG_DIFF: arg_next = bld_pkg::ARG_K;
                default:           arg_next = bld_pkg::ARG_K;
            endcase
        end
        if (do_acc) begin
            res3_next = neg ? res3_reg - inc3 : res3_reg + inc3;
            res7_next = neg ? res7_reg - inc7 : res7_reg + inc7;
            res9_next = neg ? res9_reg - inc9 : res9_reg + inc9;
            if (first_reg) begin
                // Power of 5: quotients of the unhalved argument by 5, 25, ...
                pow5_next = neg ? pow5_reg - bld_pkg::CNT_W'(q)
                                : pow5_reg + bld_pkg::CNT_W'(q);
            end
            if (q_zero) begin
                v_next     = v_reg >> 1;
                first_next = 1'b0;
            end else begin
                w_next = q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bld_pkg::ST_IDLE;
            arg_reg   <= bld_pkg::ARG_N;
            first_reg <= 1'b0;
            inv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            arg_reg   <= arg_next;
            first_reg <= first_next;
            inv_reg   <= inv_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        m_reg    <= m_next;
        v_reg    <= v_next;
        w_reg    <= w_next;
        pow2_reg <= pow2_next;
        pow5_reg <= pow5_next;
        res3_reg <= res3_next;
        res7_reg <= res7_next;
        res9_reg <= res9_next;
    end

    always_comb begin
        tally.pow2    = pow2_reg;
        tally.pow5    = pow5_reg;
        tally.res3    = res3_reg;
        tally.res7    = res7_reg;
        tally.res9    = res9_reg;
        tally.invalid = inv_reg;
    end

    `BLD_ASSERT_IMP(a_acc_nonzero, state_reg == bld_pkg::ST_ACC, w_reg != '0,
        "inner step on a zero value")
    `BLD_ASSERT_NXT(a_div_to_acc, state_reg == bld_pkg::ST_DIV,
        state_reg == bld_pkg::ST_ACC, "quotient not consumed after divide")
    `BLD_ASSERT_IMP(a_diff_nowrap,
        (state_reg == bld_pkg::ST_ARG) && (arg_reg == bld_pkg::ARG_DIFF),
        n_reg >= m_reg, "n - m wrapped on a valid item")

endmodule

/* test/bld_result_checker.sv */
// Result checker for binomial_last_nonzero_digit_top: watches both channels, predicts the
// digit of every accepted item and compares it with the results in order.
// Depends on bld_pkg for the item types and ARG_WIDTH.
module bld_result_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  bld_pkg::bld_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  bld_pkg::bld_out_t m_data,
    output int                mismatches,
    output int                outstanding,
    output int                checked,
    output int                invalid_seen,
    output int                fives_seen
);

    localparam longint unsigned ARG_MASK =
        (bld_pkg::ARG_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                   : ((64'd1 << bld_pkg::ARG_WIDTH) - 64'd1);
    localparam logic [bld_pkg::DIGIT_W-1:0] DIGIT_ONE = 4'd1;
    localparam int REPORT_LIMIT = 10;

    // Digit cycles of 2^e (e >= 1), 3^k, 7^k and 9^k, indexed by exponent mod 4.
    localparam logic [bld_pkg::DIGIT_W-1:0] TWO_POWERS   [4] = '{4'd6, 4'd2, 4'd4, 4'd8};
    localparam logic [bld_pkg::DIGIT_W-1:0] THREE_POWERS [4] = '{4'd1, 4'd3, 4'd9, 4'd7};
    localparam logic [bld_pkg::DIGIT_W-1:0] SEVEN_POWERS [4] = '{4'd1, 4'd7, 4'd9, 4'd3};
    localparam logic [bld_pkg::DIGIT_W-1:0] NINE_POWERS  [4] = '{4'd1, 4'd9, 4'd1, 4'd9};

    bld_pkg::bld_out_t expected_digits [$];
    bld_pkg::bld_out_t want;

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        checked      = 0;
        invalid_seen = 0;
        fives_seen   = 0;
    end

    // exponent of prime p in v!
    function automatic longint unsigned prime_power_in_factorial(longint unsigned v,
                                                                 longint unsigned p);
        longint unsigned sum;
        sum = 0;
        while (v >= p) begin
            v = v / p;
            sum += v;
        end
        return sum;
    endfunction

    // odd, 5-free terms ending in digit d, over the odd terms up to v
    function automatic longint unsigned odd_terms_ending(longint unsigned v,
                                                         longint unsigned d);
        longint unsigned sum;
        sum = 0;
        while (v != 0) begin
            sum += v / 10 + (((v % 10) >= d) ? 64'd1 : 64'd0);
            v = v / 5;
        end
        return sum;
    endfunction

    // factors ending in digit d in v! once every 2 and 5 is stripped
    function automatic longint unsigned factorial_terms_ending(longint unsigned v,
                                                               longint unsigned d);
        longint unsigned sum;
        sum = 0;
        while (v != 0) begin
            sum += odd_terms_ending(v, d);
            v = v / 2;
        end
        return sum;
    endfunction

    function automatic logic [1:0] ending_residue(longint unsigned n, longint unsigned k,
                                                  longint unsigned d);
        longint unsigned r;
        r = factorial_terms_ending(n, d) - factorial_terms_ending(n - k, d)
            - factorial_terms_ending(k, d);
        return r[1:0];
    endfunction

    function automatic bld_pkg::bld_out_t predict_digit(bld_pkg::bld_in_t item);
        longint unsigned   n, k, twos, fives;
        int unsigned       acc;
        bld_pkg::bld_out_t res;
        n = longint'(item.n_total) & ARG_MASK;
        k = longint'(item.k_chosen) & ARG_MASK;
        res.invalid = 1'b0;
        if (k > n) begin
            res.digit   = bld_pkg::DIGIT_NONE;
            res.invalid = 1'b1;
            return res;
        end
        twos  = prime_power_in_factorial(n, 2) - prime_power_in_factorial(n - k, 2)
                - prime_power_in_factorial(k, 2);
        fives = prime_power_in_factorial(n, 5) - prime_power_in_factorial(n - k, 5)
                - prime_power_in_factorial(k, 5);
        if (twos < fives) begin
            res.digit = bld_pkg::DIGIT_FIVE;
            return res;
        end
        if (twos == fives) acc = DIGIT_ONE;
        else acc = TWO_POWERS[2'(twos - fives)];
        acc = (acc * THREE_POWERS[ending_residue(n, k, bld_pkg::END_THREE)]) % 10;
        acc = (acc * SEVEN_POWERS[ending_residue(n, k, bld_pkg::END_SEVEN)]) % 10;
        acc = (acc * NINE_POWERS[ending_residue(n, k, bld_pkg::END_NINE)]) % 10;
        res.digit = acc[bld_pkg::DIGIT_W-1:0];
        return res;
    endfunction

    task automatic log_failure(string what, bld_pkg::bld_out_t exp_v, bld_pkg::bld_out_t got);
        if (mismatches < REPORT_LIMIT)
            $display("  mismatch at %0t: %s: expected %0d/%0d, got %0d/%0d (digit/invalid)",
                     $realtime, what, exp_v.digit, exp_v.invalid, got.digit, got.invalid);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_digits.push_back(predict_digit(s_data));
            if (m_valid && m_ready) begin
                checked++;
                if (m_data.invalid) invalid_seen++;
                if (m_data.digit == bld_pkg::DIGIT_FIVE) fives_seen++;
                if (expected_digits.size() == 0) begin
                    log_failure("result with no item pending", '0, m_data);
                end else begin
                    want = expected_digits.pop_front();
                    if (m_data.digit !== want.digit)
                        log_failure("digit field", want, m_data);
                    else if (m_data.invalid !== want.invalid)
                        log_failure("invalid field", want, m_data);
                end
            end
            outstanding <= expected_digits.size();
        end
    end

endmodule

/* test/tb_binomial_last_nonzero_digit_top.sv */
// Testbench top for binomial_last_nonzero_digit_top: drives items, idles both channels,
// stalls the result side once for a long stretch, and gives the verdict.
// Depends on bld_pkg, the block itself and bld_result_checker.
module tb_binomial_last_nonzero_digit_top;

    // Random items; most use narrow arguments because the work per item grows with their width.
    localparam int RANDOM_ITEMS   = 1200;
    // Quiet cycles tolerated: the slowest item plus the long hold-off, taken many times over.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int DRAIN_CYCLES    = 20;
    localparam int EDGE_COUNT      = 22;

    // Hand-picked {n, k} pairs: trivial coefficients, lower above upper, digit 5 cases,
    // the extremes of both fields and alternating bit patterns.
    localparam logic [63:0] EDGE_PAIRS [EDGE_COUNT] = '{
        {32'd0,          32'd0},
        {32'd0,          32'd1},
        {32'd1,          32'd0},
        {32'd1,          32'd1},
        {32'd5,          32'd2},
        {32'd7,          32'd3},
        {32'd4,          32'd2},
        {32'd10,         32'd5},
        {32'd25,         32'd5},
        {32'd100,        32'd50},
        {32'd1000,       32'd10},
        {32'hFFFF_FFFF,  32'h0000_0000},
        {32'hFFFF_FFFF,  32'hFFFF_FFFF},
        {32'hFFFF_FFFF,  32'h0000_0001},
        {32'hFFFF_FFFF,  32'hFFFF_FFFE},
        {32'hFFFF_FFFF,  32'h8000_0000},
        {32'h7FFF_FFFF,  32'hFFFF_FFFF},
        {32'hFFFF_FFFE,  32'hFFFF_FFFF},
        {32'h1234_5678,  32'h0123_4567},
        {32'h0000_0000,  32'hFFFF_FFFF},
        {32'hAAAA_AAAA,  32'h5555_5555},
        {32'h5555_5555,  32'hAAAA_AAAA}
    };

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    bld_pkg::bld_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    bld_pkg::bld_out_t m_data;

    int mismatches, outstanding, checked, invalid_seen, fives_seen;
    int unsigned items_sent    = 0;
    int unsigned results_taken = 0;
    int unsigned send_burst    = 0;
    int unsigned take_burst    = 0;
    int unsigned quiet_cycles  = 0;
    bit          held_off      = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    binomial_last_nonzero_digit_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bld_result_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .invalid_seen (invalid_seen),
        .fives_seen   (fives_seen)
    );

    // Draw the gap before the next item; now and then start a stretch with no gaps.
    function automatic int unsigned draw_gap(ref int unsigned burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
        return $urandom_range(0, 10);
    endfunction

    function automatic logic [31:0] draw_bits(int unsigned width);
        if (width >= 32) return $urandom;
        return $urandom & ((32'd1 << width) - 32'd1);
    endfunction

    // Offer one item: drop valid for the gap, then hold it with the payload until taken.
    task automatic send_item(input bld_pkg::bld_in_t item);
        int unsigned gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Mostly narrow arguments, a few full width; k usually within [0, n], sometimes above.
    task automatic send_random_item();
        int unsigned     width, pick;
        bld_pkg::bld_in_t item;
        pick = $urandom_range(0, 99);
        if (pick < 65)      width = $urandom_range(1, 8);
        else if (pick < 90) width = $urandom_range(9, 16);
        else                width = $urandom_range(17, 32);
        item.n_total = draw_bits(width);
        pick = $urandom_range(0, 99);
        if (pick < 75)      item.k_chosen = $urandom_range(item.n_total, 0);
        else if (pick < 85) item.k_chosen = draw_bits(width);
        else if (pick < 90) item.k_chosen = '0;
        else if (pick < 95) item.k_chosen = item.n_total;
        else                item.k_chosen = item.n_total + 32'd1;
        send_item(item);
    endtask

    // Result side: random gaps per result, and one long hold-off while the sender keeps going
    // so that the output register and the sequencer both fill and s_ready drops.
    initial begin
        int unsigned hold;
        while (!aresetn) @(posedge aclk);
        forever begin
            hold = draw_gap(take_burst);
            if (!held_off && results_taken >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                hold     = HOLD_OFF_CYCLES;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    // Watchdog: any handshake restarts the count of quiet cycles.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < EDGE_COUNT; i++)
            send_item(bld_pkg::bld_in_t'(EDGE_PAIRS[i]));
        repeat (RANDOM_ITEMS) send_random_item();
        s_valid <= 1'b0;

        // Drain: wait for every expected result, then let the clock run on to catch strays.
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d items (%0d hand-picked, rest mostly narrow), %0d results checked",
                 items_sent, EDGE_COUNT, checked);
        $display("Summary: %0d lower above upper, %0d digit 5, one %0d-cycle result hold-off",
                 invalid_seen, fives_seen, HOLD_OFF_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
